// ----- hw/rtl/qrs_pkg.sv -----
// Shared constants, result codes and the pipeline control bundle of the
// quadratic root solver. No dependencies.
package qrs_pkg;

  // Coefficient width and fraction bits (signed Q16.16)
  localparam int CW  = 32;
  localparam int FB  = 16;
  // Magnitude plus one bit: 2*|a|, -b, -c
  localparam int BW  = CW + 1;
  // Products and discriminant
  localparam int PW  = 2 * CW;
  localparam int DW  = 2 * CW + 2;
  // Square root width (floor sqrt of a DW-bit value)
  localparam int SW  = CW + 1;
  // Signed numerator -b -+ s, and its magnitude
  localparam int NSW = CW + 3;
  localparam int NW  = CW + 2;
  // Stream widths
  localparam int IN_W  = 3 * CW;
  localparam int OUT_W = ((2 + 2 * CW + 1 + 7) / 8) * 8;

  // Root count codes
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_ALL  = 2'd3;

  // Control carried alongside the datapath
  typedef struct packed {
    logic [1:0]           count;
    logic                 den_neg;
    logic [BW-1:0]        den_mag;
    logic signed [BW-1:0] base;
  } ctrl_t;

endpackage

// ----- hw/rtl/qrs_disc.sv -----
// Front end: sign split, the two 32x32 products and the exact discriminant,
// three register stages. Depends on qrs_pkg.
module qrs_disc (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ce,
  input  logic                      in_valid,
  input  logic [qrs_pkg::CW-1:0]    in_a,
  input  logic [qrs_pkg::CW-1:0]    in_b,
  input  logic [qrs_pkg::CW-1:0]    in_c,
  output logic                      out_valid,
  output logic [qrs_pkg::DW-1:0]    out_disc,
  output qrs_pkg::ctrl_t            out_ctrl
);

  // stage 1: signs and magnitudes
  logic                     v1;
  logic                     an1, bn1, cn1;
  logic [qrs_pkg::CW-1:0]   am1, bm1, cm1, b1, c1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (ce) v1 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      an1 <= in_a[qrs_pkg::CW-1];
      bn1 <= in_b[qrs_pkg::CW-1];
      cn1 <= in_c[qrs_pkg::CW-1];
      am1 <= in_a[qrs_pkg::CW-1] ? (~in_a + 1'b1) : in_a;
      bm1 <= in_b[qrs_pkg::CW-1] ? (~in_b + 1'b1) : in_b;
      cm1 <= in_c[qrs_pkg::CW-1] ? (~in_c + 1'b1) : in_c;
      b1  <= in_b;
      c1  <= in_c;
    end
  end

  // stage 2: b*b and a*c
  logic                     v2;
  logic                     an2, bn2, cn2;
  logic                     az2, bz2, cz2;
  logic [qrs_pkg::CW-1:0]   am2, bm2, b2, c2;
  logic [qrs_pkg::PW-1:0]   bsq2, ac2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (ce) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      an2  <= an1;
      bn2  <= bn1;
      cn2  <= cn1;
      az2  <= (am1 == '0);
      bz2  <= (bm1 == '0);
      cz2  <= (cm1 == '0);
      am2  <= am1;
      bm2  <= bm1;
      b2   <= b1;
      c2   <= c1;
      bsq2 <= qrs_pkg::PW'(bm1) * qrs_pkg::PW'(bm1);
      ac2  <= qrs_pkg::PW'(am1) * qrs_pkg::PW'(cm1);
    end
  end

  // stage 3: discriminant and case decision
  logic [qrs_pkg::DW-1:0] bsq_x, prod_x, disc_next;
  logic                   ac_neg, disc_ge, disc_zero;
  qrs_pkg::ctrl_t         ctrl_next;

  always_comb begin
    bsq_x     = qrs_pkg::DW'(bsq2);
    prod_x    = qrs_pkg::DW'(ac2) << 2;
    ac_neg    = (an2 != cn2) && !cz2;
    disc_ge   = bsq_x >= prod_x;
    disc_zero = !ac_neg && (bsq_x == prod_x);
    disc_next = ac_neg ? (bsq_x + prod_x) : (bsq_x - prod_x);
    ctrl_next.den_neg = an2;
    ctrl_next.den_mag = {am2, 1'b0};
    ctrl_next.base    = qrs_pkg::BW'(0) - {b2[qrs_pkg::CW-1], b2};
    if (az2) begin
      // linear case: root is -c/b, no square root needed
      disc_next         = '0;
      ctrl_next.den_neg = bn2;
      ctrl_next.den_mag = {1'b0, bm2};
      ctrl_next.base    = qrs_pkg::BW'(0) - {c2[qrs_pkg::CW-1], c2};
      if (bz2) ctrl_next.count = cz2 ? qrs_pkg::CNT_ALL : qrs_pkg::CNT_NONE;
      else ctrl_next.count = qrs_pkg::CNT_ONE;
    end else if (!ac_neg && !disc_ge) begin
      disc_next       = '0;
      ctrl_next.count = qrs_pkg::CNT_NONE;
    end else if (disc_zero) begin
      ctrl_next.count = qrs_pkg::CNT_ONE;
    end else begin
      ctrl_next.count = qrs_pkg::CNT_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ce) out_valid <= v2;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_disc <= disc_next;
      out_ctrl <= ctrl_next;
    end
  end

endmodule

// ----- hw/rtl/qrs_isqrt.sv -----
// Pipelined floor square root of the discriminant, one root bit per stage.
// Depends on qrs_pkg.
module qrs_isqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ce,
  input  logic                      in_valid,
  input  logic [qrs_pkg::DW-1:0]    in_disc,
  input  qrs_pkg::ctrl_t            in_ctrl,
  output logic                      out_valid,
  output logic [qrs_pkg::SW-1:0]    out_root,
  output qrs_pkg::ctrl_t            out_ctrl
);

  logic                   vld  [0:qrs_pkg::SW];
  logic [qrs_pkg::DW-1:0] rem  [0:qrs_pkg::SW];
  logic [qrs_pkg::SW-1:0] root [0:qrs_pkg::SW];
  qrs_pkg::ctrl_t         ctl  [0:qrs_pkg::SW];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_disc;
  assign root[0] = '0;
  assign ctl[0]  = in_ctrl;

  for (genvar g = 0; g < qrs_pkg::SW; g++) begin : g_stage
    localparam int BIT = qrs_pkg::SW - 1 - g;
    logic [qrs_pkg::DW-1:0] trial;
    logic                   take;

    // (r + 2^i)^2 <= D  <=>  D - r^2 >= r*2^(i+1) + 2^(2i)
    always_comb begin
      trial = (qrs_pkg::DW'(root[g]) << (BIT + 1)) | (qrs_pkg::DW'(1) << (2 * BIT));
      take  = rem[g] >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else if (ce) vld[g+1] <= vld[g];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[g+1]  <= take ? (rem[g] - trial) : rem[g];
        root[g+1] <= take ? (root[g] | (qrs_pkg::SW'(1) << BIT)) : root[g];
        ctl[g+1]  <= ctl[g];
      end
    end
  end

  assign out_valid = vld[qrs_pkg::SW];
  assign out_root  = root[qrs_pkg::SW];
  assign out_ctrl  = ctl[qrs_pkg::SW];

endmodule

// ----- hw/rtl/qrs_div.sv -----
// Pipelined scaled divider: trunc(num * 2^FB / den) with saturation to the
// signed coefficient range, one quotient bit per stage. Depends on qrs_pkg.
module qrs_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic [qrs_pkg::NW-1:0]       in_num,
  input  logic [qrs_pkg::BW-1:0]       in_den,
  input  logic                         in_neg,
  input  qrs_pkg::ctrl_t               in_ctrl,
  output logic                         out_valid,
  output logic signed [qrs_pkg::CW-1:0] out_quo,
  output logic                         out_ovf,
  output qrs_pkg::ctrl_t               out_ctrl
);

  localparam int QW = qrs_pkg::CW;

  logic                   vld [0:QW];
  logic [qrs_pkg::DW-1:0] rem [0:QW];
  logic [qrs_pkg::BW-1:0] den [0:QW];
  logic [QW-1:0]          quo [0:QW];
  logic                   big [0:QW];
  logic                   neg [0:QW];
  qrs_pkg::ctrl_t         ctl [0:QW];

  // entry: scale the numerator, flag quotients of 2^QW or more
  logic [qrs_pkg::DW-1:0] scaled;

  assign scaled = qrs_pkg::DW'({in_num, qrs_pkg::FB'(0)});

  always_ff @(posedge clk) begin
    if (rst) vld[0] <= 1'b0;
    else if (ce) vld[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem[0] <= scaled;
      den[0] <= in_den;
      quo[0] <= '0;
      big[0] <= scaled >= (qrs_pkg::DW'(in_den) << QW);
      neg[0] <= in_neg;
      ctl[0] <= in_ctrl;
    end
  end

  // restoring division, most significant quotient bit first
  for (genvar g = 0; g < QW; g++) begin : g_stage
    localparam int BIT = QW - 1 - g;
    logic [qrs_pkg::DW-1:0] sub;
    logic                   take;

    always_comb begin
      sub  = qrs_pkg::DW'(den[g]) << BIT;
      take = rem[g] >= sub;
    end

    always_ff @(posedge clk) begin
      if (rst) vld[g+1] <= 1'b0;
      else if (ce) vld[g+1] <= vld[g];
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[g+1] <= take ? (rem[g] - sub) : rem[g];
        quo[g+1] <= take ? (quo[g] | (QW'(1) << BIT)) : quo[g];
        den[g+1] <= den[g];
        big[g+1] <= big[g];
        neg[g+1] <= neg[g];
        ctl[g+1] <= ctl[g];
      end
    end
  end

  // exit: saturate and apply the sign
  logic [QW-1:0] lim, mag;
  logic          sat;

  always_comb begin
    lim = neg[QW] ? (QW'(1) << (QW - 1)) : ((QW'(1) << (QW - 1)) - 1'b1);
    sat = big[QW] || (quo[QW] > lim);
    mag = sat ? lim : quo[QW];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (ce) out_valid <= vld[QW];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_quo  <= neg[QW] ? $signed(QW'(0) - mag) : $signed(mag);
      out_ovf  <= sat;
      out_ctrl <= ctl[QW];
    end
  end

endmodule

// ----- hw/rtl/quadratic_root_solver.sv -----
// Top level of the quadratic root solver: discriminant front end, square
// root pipeline, two scaled dividers and the output register. Uses qrs_pkg.
//
//  channel   dir  width  content
//  s_axis    in   96     coef_a [31:0], coef_b [63:32], coef_c [95:64]
//  m_axis    out  72     root_count, root_low, root_high, overflow
//
// One equation enters per cycle unless the output is held; a result passes
// through 3 front stages, 33 square root stages, the numerator stage, 34
// divider stages and the output register. The square root and divider bit
// stages set the depth. Reset clears only the valid bits. When the output
// is held by m_tready the whole pipeline stalls in place and s_tready drops.
module quadratic_root_solver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // coef_a, coef_b, coef_c from bit 0 up
  input  logic [qrs_pkg::IN_W-1:0]    s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // root_count, root_low, root_high, overflow from bit 0 up, zero filled
  output logic [qrs_pkg::OUT_W-1:0]   m_tdata
);

  localparam int CW = qrs_pkg::CW;

  logic ce;

  // global advance: move when the output slot is free or being taken
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // discriminant
  logic                   d_valid;
  logic [qrs_pkg::DW-1:0] d_disc;
  qrs_pkg::ctrl_t         d_ctrl;

  qrs_disc u_disc (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .in_a      (s_tdata[CW-1:0]),
    .in_b      (s_tdata[2*CW-1:CW]),
    .in_c      (s_tdata[3*CW-1:2*CW]),
    .out_valid (d_valid),
    .out_disc  (d_disc),
    .out_ctrl  (d_ctrl)
  );

  // square root
  logic                   q_valid;
  logic [qrs_pkg::SW-1:0] q_root;
  qrs_pkg::ctrl_t         q_ctrl;
  qrs_pkg::ctrl_t         q_ctrl_in;

  assign q_ctrl_in = d_ctrl;

  qrs_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (d_valid),
    .in_disc   (d_disc),
    .in_ctrl   (q_ctrl_in),
    .out_valid (q_valid),
    .out_root  (q_root),
    .out_ctrl  (q_ctrl)
  );

  // numerators base -+ s, split into sign and magnitude
  logic signed [qrs_pkg::NSW-1:0] base_x, root_x, n1, n2;
  logic                           n_valid, n1_neg, n2_neg;
  logic [qrs_pkg::NW-1:0]         n1_mag, n2_mag;
  logic [qrs_pkg::BW-1:0]         n_den;
  qrs_pkg::ctrl_t                 n_ctrl;

  always_comb begin
    base_x = qrs_pkg::NSW'(q_ctrl.base);
    root_x = $signed(qrs_pkg::NSW'(q_root));
    n1     = base_x - root_x;
    n2     = base_x + root_x;
  end

  always_ff @(posedge clk) begin
    if (rst) n_valid <= 1'b0;
    else if (ce) n_valid <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n1_neg <= n1[qrs_pkg::NSW-1] != q_ctrl.den_neg;
      n2_neg <= n2[qrs_pkg::NSW-1] != q_ctrl.den_neg;
      n1_mag <= qrs_pkg::NW'(n1[qrs_pkg::NSW-1] ? -n1 : n1);
      n2_mag <= qrs_pkg::NW'(n2[qrs_pkg::NSW-1] ? -n2 : n2);
      n_den  <= q_ctrl.den_mag;
      n_ctrl <= q_ctrl;
    end
  end

  // two dividers in lockstep
  logic                  v1, v2, ovf1, ovf2;
  logic signed [CW-1:0]  r1, r2;
  qrs_pkg::ctrl_t        r_ctrl;

  qrs_div u_div_lo (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (n_valid),
    .in_num    (n1_mag),
    .in_den    (n_den),
    .in_neg    (n1_neg),
    .in_ctrl   (n_ctrl),
    .out_valid (v1),
    .out_quo   (r1),
    .out_ovf   (ovf1),
    .out_ctrl  (r_ctrl)
  );

  qrs_div u_div_hi (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (n_valid),
    .in_num    (n2_mag),
    .in_den    (n_den),
    .in_neg    (n2_neg),
    .in_ctrl   (n_ctrl),
    .out_valid (v2),
    .out_quo   (r2),
    .out_ovf   (ovf2),
    .out_ctrl  ()
  );

  // ordering and output formatting
  logic [1:0]           cnt;
  logic signed [CW-1:0] lo_next, hi_next;
  logic                 ovf_next;

  always_comb begin
    cnt      = r_ctrl.count;
    lo_next  = '0;
    hi_next  = '0;
    ovf_next = 1'b0;
    case (cnt)
      qrs_pkg::CNT_ONE: begin
        lo_next  = r1;
        ovf_next = ovf1;
      end
      qrs_pkg::CNT_TWO: begin
        lo_next  = (r1 < r2) ? r1 : r2;
        hi_next  = (r1 < r2) ? r2 : r1;
        ovf_next = ovf1 || ovf2;
      end
      default: begin
        lo_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (ce) m_tvalid <= v1 && v2;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= qrs_pkg::OUT_W'({ovf_next, hi_next, lo_next, cnt});
    end
  end

endmodule
